FILE: src/ipl4hp_pkg.sv
// Package for the IP/layer-4 header parser: word types for both channels,
// status codes, protocol constants and the register map.
// Depends on nothing; every other file imports it.
package ipl4hp_pkg;

    // Input word: one frame byte with its end marker and timestamp.
    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [63:0] arrival_time;
    } in_word_t;

    // Result word: one per frame.
    typedef struct packed {
        logic [2:0]  parse_status;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        fin_flag;
        logic        rst_flag;
        logic [6:0]  header_bytes;
        logic [13:0] payload_bytes;
        logic [63:0] stamp;
    } out_word_t;

    // Parse status codes.
    localparam logic [2:0] STATUS_IPV4_OK    = 3'd0;
    localparam logic [2:0] STATUS_IPV6_OK    = 3'd1;
    localparam logic [2:0] STATUS_NOT_IP     = 3'd2;
    localparam logic [2:0] STATUS_NOT_L4     = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;

    // IP versions and layer-4 protocol numbers.
    localparam logic [3:0] IP_VER4     = 4'd4;
    localparam logic [3:0] IP_VER6     = 4'd6;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;

    // Fixed header geometry.
    localparam logic [6:0] IPV6_HDR_BYTES  = 7'd40;
    localparam logic [6:0] UDP_HDR_BYTES   = 7'd8;
    localparam logic [6:0] IPV4_MIN_NEED   = 7'd20;
    localparam logic [6:0] IPV6_NEED       = 7'd44;
    localparam logic [6:0] IPV4_PROTO_NEED = 7'd10;
    localparam logic [6:0] IPV6_PROTO_NEED = 7'd7;

    // Register map.
    localparam int          PADDR_W         = 3;
    localparam logic        REG_LINK_HDR    = 1'b0;
    localparam logic [6:0]  LINK_HDR_RESET  = 7'd14;

endpackage

FILE: src/ip_l4_header_parser_unit.sv
// IP/layer-4 five-tuple parser, top level.
// Depends on ipl4hp_pkg for word types, status codes and constants.
//
// The parser takes one frame byte per word and accepts a new word every clock
// cycle for as long as results are taken. Each byte passes an input register,
// is captured by its position after the link header, and on the frame's last
// byte the result word is built in the same pass and held in the result
// register, where m_valid announces it.
// A result waiting on m_ready stalls the input only when the next last byte
// needs the result register. The link header length register (byte address 0)
// must only be changed between frames.
module ip_l4_header_parser_unit
    import ipl4hp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16383
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Frame byte channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    // Registers
    logic [6:0]        lhb_reg;
    logic              in_valid_reg;
    in_word_t          in_reg;
    logic              m_valid_reg;
    out_word_t         out_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [3:0]        ver_reg;
    logic [3:0]        ihl_reg;
    logic [7:0]        proto_reg;
    logic [63:0]       addr_reg [4];
    logic [15:0]       sport_reg;
    logic [15:0]       dport_reg;
    logic [7:0]        flags_reg;
    logic [3:0]        off_reg;
    logic [63:0]       stamp_reg;

    // Next values after the byte in the input register is captured
    logic [POS_W-1:0]  pos_next;
    logic [3:0]        ver_next;
    logic [3:0]        ihl_next;
    logic [7:0]        proto_next;
    logic [63:0]       addr_next [4];
    logic [15:0]       sport_next;
    logic [15:0]       dport_next;
    logic [7:0]        flags_next;
    logic [3:0]        off_next;
    logic [63:0]       stamp_next;
    out_word_t         out_next;

    // Working signals
    logic              adv;
    logic              first;
    logic              cap_en;
    logic [7:0]        b;
    logic [POS_W-1:0]  lhb_ext;
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  r_m8;
    logic [1:0]        slot;
    logic              rz;
    logic [6:0]        l4;
    logic [POS_W-1:0]  l4_r;
    logic [POS_W-1:0]  count;
    logic [POS_W-1:0]  rem;
    logic [6:0]        need;
    logic [6:0]        ihl4;
    logic [6:0]        hdr;
    logic [2:0]        status;
    logic              cfg_wr;

    // Configuration port: zero wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LINK_HDR);
    assign prdata = (paddr[2] == REG_LINK_HDR) ? {25'd0, lhb_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lhb_reg <= LINK_HDR_RESET;
        end else if (cfg_wr) begin
            lhb_reg <= pwdata[6:0];
        end
    end

    // Pipeline control: a byte that ends a frame needs a free result register.
    assign adv     = in_valid_reg && (!in_reg.frame_last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Position of the byte relative to the start of the IP header.
    assign b       = in_reg.frame_byte;
    assign first   = (pos_reg == '0);
    assign lhb_ext = POS_W'(lhb_reg);
    assign cap_en  = (pos_reg < POS_MAX) && (pos_reg >= lhb_ext);
    assign r       = pos_reg - lhb_ext;
    assign r_m8    = r - POS_W'(8);
    assign slot    = r_m8[4:3];
    assign rz      = cap_en && (r == '0);
    assign count   = (pos_reg < POS_MAX) ? POS_W'(pos_reg + 1'b1) : POS_MAX;

    // Byte capture: captures restart at the first byte of a frame.
    always_comb begin
        ver_next   = first ? 4'd0  : ver_reg;
        ihl_next   = first ? 4'd0  : ihl_reg;
        proto_next = first ? 8'd0  : proto_reg;
        sport_next = first ? 16'd0 : sport_reg;
        dport_next = first ? 16'd0 : dport_reg;
        flags_next = first ? 8'd0  : flags_reg;
        off_next   = first ? 4'd0  : off_reg;
        stamp_next = first ? in_reg.arrival_time : stamp_reg;
        for (int i = 0; i < 4; i++) begin
            addr_next[i] = first ? 64'd0 : addr_reg[i];
        end

        if (rz) begin
            ver_next = b[7:4];
            ihl_next = b[3:0];
        end
        l4   = (ver_next == IP_VER6) ? IPV6_HDR_BYTES : {1'b0, ihl_next, 2'b00};
        l4_r = POS_W'(l4);

        if (cap_en) begin
            if (ver_next == IP_VER4) begin
                if (r == POS_W'(9)) begin
                    proto_next = b;
                end
                if (r >= POS_W'(12) && r < POS_W'(16)) begin
                    addr_next[1] = {addr_next[1][55:0], b};
                end
                if (r >= POS_W'(16) && r < POS_W'(20)) begin
                    addr_next[3] = {addr_next[3][55:0], b};
                end
            end else if (ver_next == IP_VER6) begin
                if (r == POS_W'(6)) begin
                    proto_next = b;
                end
                if (r >= POS_W'(8) && r < POS_W'(40)) begin
                    addr_next[slot] = {addr_next[slot][55:0], b};
                end
            end
            if (r >= l4_r && r < l4_r + POS_W'(2)) begin
                sport_next = {sport_next[7:0], b};
            end
            if (r >= l4_r + POS_W'(2) && r < l4_r + POS_W'(4)) begin
                dport_next = {dport_next[7:0], b};
            end
            if (r == l4_r + POS_W'(12)) begin
                off_next = b[7:4];
            end
            if (r == l4_r + POS_W'(13)) begin
                flags_next = b;
            end
        end
    end

    // Frame status and lengths, from the captures including this byte.
    always_comb begin
        rem  = count - lhb_ext;
        ihl4 = {1'b0, ihl_next, 2'b00};
        need = ihl4 + 7'd4;
        if (ver_next == IP_VER6) begin
            need = IPV6_NEED;
        end else if (need < IPV4_MIN_NEED) begin
            need = IPV4_MIN_NEED;
        end

        priority if (count <= lhb_ext) begin
            status = STATUS_TRUNCATED;
        end else if (ver_next != IP_VER4 && ver_next != IP_VER6) begin
            status = STATUS_NOT_IP;
        end else if (ver_next == IP_VER4 && rem < POS_W'(IPV4_PROTO_NEED)) begin
            status = STATUS_TRUNCATED;
        end else if (ver_next == IP_VER6 && rem < POS_W'(IPV6_PROTO_NEED)) begin
            status = STATUS_TRUNCATED;
        end else if (proto_next != PROTO_TCP && proto_next != PROTO_UDP) begin
            status = STATUS_NOT_L4;
        end else if (rem < POS_W'(need)) begin
            status = STATUS_TRUNCATED;
        end else if (ver_next == IP_VER4) begin
            status = STATUS_IPV4_OK;
        end else begin
            status = STATUS_IPV6_OK;
        end

        hdr = ((ver_next == IP_VER4) ? ihl4 : IPV6_HDR_BYTES)
            + ((proto_next == PROTO_TCP) ? {1'b0, off_next, 2'b00} : UDP_HDR_BYTES);

        out_next              = '0;
        out_next.parse_status = status;
        out_next.stamp        = stamp_next;
        if (status == STATUS_IPV4_OK || status == STATUS_IPV6_OK) begin
            out_next.source_high = addr_next[0];
            out_next.source_low  = addr_next[1];
            out_next.dest_high   = addr_next[2];
            out_next.dest_low    = addr_next[3];
            out_next.source_port = sport_next;
            out_next.dest_port   = dport_next;
            if (proto_next == PROTO_TCP) begin
                out_next.fin_flag = flags_next[0];
                out_next.rst_flag = flags_next[2];
            end
            if (POS_W'(hdr) > rem) begin
                out_next.header_bytes  = rem[6:0];
                out_next.payload_bytes = 14'd0;
            end else begin
                out_next.header_bytes  = hdr;
                out_next.payload_bytes = 14'(rem - POS_W'(hdr));
            end
        end
    end

    assign pos_next = in_reg.frame_last ? '0 : count;

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ver_reg   <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            flags_reg <= '0;
            off_reg   <= '0;
            stamp_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                addr_reg[i] <= '0;
            end
        end else if (adv) begin
            pos_reg   <= pos_next;
            ver_reg   <= ver_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            flags_reg <= flags_next;
            off_reg   <= off_next;
            stamp_reg <= stamp_next;
            for (int i = 0; i < 4; i++) begin
                addr_reg[i] <= addr_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && in_reg.frame_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_reg.frame_last) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: src/ipl4hp_checker.sv
// Port-level checker for the IP/layer-4 header parser, bound to the top level.
// Depends on ipl4hp_pkg for the result word type and status codes.
module ipl4hp_checker
    import ipl4hp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Only defined status codes are reported.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.parse_status <= STATUS_TRUNCATED)
        else $error("undefined parse status");

    // A failed parse carries only status and timestamp.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.parse_status != STATUS_IPV4_OK
                && m_data.parse_status != STATUS_IPV6_OK
        |-> m_data.source_high == '0 && m_data.source_low == '0
            && m_data.dest_high == '0 && m_data.dest_low == '0
            && m_data.source_port == '0 && m_data.dest_port == '0
            && !m_data.fin_flag && !m_data.rst_flag
            && m_data.header_bytes == '0 && m_data.payload_bytes == '0)
        else $error("failed parse with nonzero fields");

    // IPv4 addresses occupy only the low 32 bits.
    a_ipv4_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.parse_status == STATUS_IPV4_OK
        |-> m_data.source_high == '0 && m_data.dest_high == '0
            && m_data.source_low[63:32] == '0 && m_data.dest_low[63:32] == '0)
        else $error("IPv4 address outside low word");

    // Header length never exceeds the largest IP plus layer-4 header.
    a_hdr_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.header_bytes <= 7'd120)
        else $error("header length out of range");

endmodule

bind ip_l4_header_parser_unit ipl4hp_checker u_ipl4hp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: test/testbench.sv
// Self-checking testbench for ip_l4_header_parser_unit: drives Ethernet frames byte by byte
// and checks every result word against a predictor of the five-tuple parser.
// Depends on ipl4hp_pkg and the RTL under src/.
`timescale 1ns / 1ps

module testbench;
    import ipl4hp_pkg::*;

    localparam int MAX_BYTES    = 16383;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 325;
    localparam int PHASE_FRAMES = 8;
    localparam int PRINT_CAP    = 40;
    localparam logic [PADDR_W-1:0] LINK_ADDR = PADDR_W'(4 * int'(REG_LINK_HDR));

    // One directed frame: link header length, IP and layer-4 header settings, bytes after the
    // link header, and an optional typed-in status for results that are plain failures.
    typedef struct packed {
        logic [6:0]  link;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [3:0]  off;
        logic [7:0]  flags;
        logic [15:0] rem;
        logic        pin;
        logic [2:0]  status;
    } frame_case_t;

    localparam frame_case_t DIRECTED [25] = '{
        // Frame ends inside the link header, then exactly at the version byte.
        '{7'd14, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h00, 16'd0, 1'b1, STATUS_TRUNCATED},
        '{7'd14, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h00, 16'd1, 1'b1, STATUS_TRUNCATED},
        // IPv4 frame ending before the protocol byte, then one byte short of the ports.
        '{7'd14, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h00, 16'd9, 1'b1, STATUS_TRUNCATED},
        '{7'd14, IP_VER4, 4'd5, PROTO_UDP, 4'd0, 8'h00, 16'd23, 1'b1, STATUS_TRUNCATED},
        '{7'd14, IP_VER4, 4'd5, PROTO_UDP, 4'd0, 8'h00, 16'd24, 1'b0, STATUS_IPV4_OK},
        '{7'd14, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h05, 16'd40, 1'b0, STATUS_IPV4_OK},
        // Largest IPv4 and TCP headers, then the same frame cut before the TCP offset.
        '{7'd14, IP_VER4, 4'd15, PROTO_TCP, 4'd15, 8'hFF, 16'd120, 1'b0, STATUS_IPV4_OK},
        '{7'd14, IP_VER4, 4'd15, PROTO_TCP, 4'd15, 8'hFF, 16'd70, 1'b0, STATUS_IPV4_OK},
        // Header length below 20 bytes makes the layer-4 fields overlap the IPv4 header bytes.
        '{7'd14, IP_VER4, 4'd2, PROTO_UDP, 4'd0, 8'h00, 16'd30, 1'b0, STATUS_IPV4_OK},
        '{7'd14, IP_VER4, 4'd0, PROTO_TCP, 4'd5, 8'h01, 16'd20, 1'b0, STATUS_IPV4_OK},
        // Versions other than 4 and 6.
        '{7'd14, 4'd5, 4'd5, PROTO_TCP, 4'd0, 8'h00, 16'd60, 1'b1, STATUS_NOT_IP},
        '{7'd14, 4'd0, 4'd0, PROTO_TCP, 4'd0, 8'h00, 16'd30, 1'b1, STATUS_NOT_IP},
        '{7'd14, 4'd15, 4'd15, PROTO_UDP, 4'd0, 8'h00, 16'd30, 1'b1, STATUS_NOT_IP},
        // Protocols other than TCP and UDP.
        '{7'd14, IP_VER4, 4'd5, 8'd1, 4'd0, 8'h00, 16'd60, 1'b1, STATUS_NOT_L4},
        '{7'd14, IP_VER4, 4'd5, 8'hFF, 4'd0, 8'h00, 16'd60, 1'b1, STATUS_NOT_L4},
        // IPv6 cases: good TCP, UDP at the exact minimum, one short, other protocol, no proto.
        '{7'd14, IP_VER6, 4'd0, PROTO_TCP, 4'd5, 8'h01, 16'd80, 1'b0, STATUS_IPV6_OK},
        '{7'd14, IP_VER6, 4'd0, PROTO_UDP, 4'd0, 8'h00, 16'd44, 1'b0, STATUS_IPV6_OK},
        '{7'd14, IP_VER6, 4'd0, PROTO_UDP, 4'd0, 8'h00, 16'd43, 1'b1, STATUS_TRUNCATED},
        '{7'd14, IP_VER6, 4'd0, 8'd50, 4'd0, 8'h00, 16'd50, 1'b1, STATUS_NOT_L4},
        '{7'd14, IP_VER6, 4'd0, PROTO_TCP, 4'd0, 8'h00, 16'd6, 1'b1, STATUS_TRUNCATED},
        // IPv6 TCP frame that ends before the TCP offset byte.
        '{7'd14, IP_VER6, 4'd15, PROTO_TCP, 4'd15, 8'h04, 16'd50, 1'b0, STATUS_IPV6_OK},
        // Frame longer than the byte counter saturates at.
        '{7'd14, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h11, 16'd16500, 1'b0, STATUS_IPV4_OK},
        // No link header: single-byte frame, then a good UDP frame.
        '{7'd0, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 8'h00, 16'd1, 1'b1, STATUS_TRUNCATED},
        '{7'd0, IP_VER4, 4'd5, PROTO_UDP, 4'd0, 8'h00, 16'd28, 1'b0, STATUS_IPV4_OK},
        // Longest link header.
        '{7'd127, IP_VER6, 4'd0, PROTO_UDP, 4'd0, 8'h00, 16'd100, 1'b0, STATUS_IPV6_OK}
    };

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state: configuration copy and per-frame captures.
    logic [6:0]  link_hdr_len = LINK_HDR_RESET;
    int unsigned byte_pos     = 0;
    logic [3:0]  cur_ver      = '0;
    logic [3:0]  cur_ihl      = '0;
    logic [7:0]  cur_proto    = '0;
    logic [63:0] addr_acc [4] = '{default: '0};
    logic [15:0] port_acc [2] = '{default: '0};
    logic [7:0]  tcp_flags    = '0;
    logic [3:0]  tcp_off      = '0;
    logic [63:0] frame_time   = '0;

    out_word_t   expected_q [$];
    logic [7:0]  frame_bytes [$];
    bit          idle_on      = 1'b0;
    bit          hold_long    = 1'b0;
    int          mismatches   = 0;
    int          results_seen = 0;
    int unsigned cycle_count  = 0;

    ip_l4_header_parser_unit #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
    endtask

    // Advances the parser by one frame byte; returns 1 with the result word on the last byte.
    function automatic bit parse_byte(input in_word_t w, output out_word_t res);
        int unsigned r, l4, cnt, rem, hdr, pay, need;
        logic [3:0]  v, h;
        logic [7:0]  b;
        logic [2:0]  st;
        res = '0;
        b = w.frame_byte;
        if (byte_pos == 0) begin
            cur_ver = '0;
            cur_ihl = '0;
            cur_proto = '0;
            addr_acc = '{default: '0};
            port_acc = '{default: '0};
            tcp_flags = '0;
            tcp_off = '0;
            frame_time = w.arrival_time;
        end

        // Capture by position after the link header.
        if (byte_pos < MAX_BYTES && byte_pos >= link_hdr_len) begin
            r = byte_pos - link_hdr_len;
            v = (r == 0) ? b[7:4] : cur_ver;
            h = (r == 0) ? b[3:0] : cur_ihl;
            l4 = (v == IP_VER6) ? 40 : 4 * int'(h);
            if (r == 0) begin
                cur_ver = v;
                cur_ihl = h;
            end
            if (v == IP_VER4) begin
                if (r == 9)
                    cur_proto = b;
                if (r >= 12 && r < 16)
                    addr_acc[1] = {addr_acc[1][55:0], b};
                if (r >= 16 && r < 20)
                    addr_acc[3] = {addr_acc[3][55:0], b};
            end else if (v == IP_VER6) begin
                if (r == 6)
                    cur_proto = b;
                if (r >= 8 && r < 40)
                    addr_acc[(r - 8) >> 3] = {addr_acc[(r - 8) >> 3][55:0], b};
            end
            if (r >= l4 && r < l4 + 2)
                port_acc[0] = {port_acc[0][7:0], b};
            if (r >= l4 + 2 && r < l4 + 4)
                port_acc[1] = {port_acc[1][7:0], b};
            if (r == l4 + 12)
                tcp_off = b[7:4];
            if (r == l4 + 13)
                tcp_flags = b;
        end

        cnt = (byte_pos + 1 > MAX_BYTES) ? MAX_BYTES : byte_pos + 1;
        if (!w.frame_last) begin
            byte_pos = cnt;
            return 1'b0;
        end
        byte_pos = 0;

        // Status: the frame must reach the version, protocol and port bytes.
        rem = (cnt > link_hdr_len) ? cnt - link_hdr_len : 0;
        if (cnt <= link_hdr_len) begin
            st = STATUS_TRUNCATED;
        end else if (cur_ver != IP_VER4 && cur_ver != IP_VER6) begin
            st = STATUS_NOT_IP;
        end else if (rem < ((cur_ver == IP_VER4) ? IPV4_PROTO_NEED : IPV6_PROTO_NEED)) begin
            st = STATUS_TRUNCATED;
        end else if (cur_proto != PROTO_TCP && cur_proto != PROTO_UDP) begin
            st = STATUS_NOT_L4;
        end else begin
            need = (cur_ver == IP_VER6) ? IPV6_NEED : 4 * int'(cur_ihl) + 4;
            if (need < IPV4_MIN_NEED)
                need = IPV4_MIN_NEED;
            if (rem < need)
                st = STATUS_TRUNCATED;
            else
                st = (cur_ver == IP_VER4) ? STATUS_IPV4_OK : STATUS_IPV6_OK;
        end
        res.parse_status = st;
        res.stamp = frame_time;
        if (st != STATUS_IPV4_OK && st != STATUS_IPV6_OK)
            return 1'b1;

        // Header and payload lengths, header clamped to the frame.
        hdr = (cur_ver == IP_VER4) ? 4 * int'(cur_ihl) : IPV6_HDR_BYTES;
        hdr += (cur_proto == PROTO_TCP) ? 4 * int'(tcp_off) : UDP_HDR_BYTES;
        if (hdr > rem) begin
            hdr = rem;
            pay = 0;
        end else begin
            pay = rem - hdr;
        end
        res.source_high = addr_acc[0];
        res.source_low = addr_acc[1];
        res.dest_high = addr_acc[2];
        res.dest_low = addr_acc[3];
        res.source_port = port_acc[0];
        res.dest_port = port_acc[1];
        if (cur_proto == PROTO_TCP) begin
            res.fin_flag = tcp_flags[0];
            res.rst_flag = tcp_flags[2];
        end
        res.header_bytes = hdr[6:0];
        res.payload_bytes = pay[13:0];
        return 1'b1;
    endfunction

    // Compares one result word with the oldest expected one.
    task automatic check_result(input out_word_t got);
        out_word_t want;
        results_seen++;
        if (expected_q.size() == 0) begin
            flag_mismatch("result word with none expected, status", got.parse_status, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.parse_status !== want.parse_status)
            flag_mismatch("parse_status", got.parse_status, want.parse_status);
        if (got.source_high !== want.source_high)
            flag_mismatch("source_high", got.source_high, want.source_high);
        if (got.source_low !== want.source_low)
            flag_mismatch("source_low", got.source_low, want.source_low);
        if (got.dest_high !== want.dest_high)
            flag_mismatch("dest_high", got.dest_high, want.dest_high);
        if (got.dest_low !== want.dest_low)
            flag_mismatch("dest_low", got.dest_low, want.dest_low);
        if (got.source_port !== want.source_port)
            flag_mismatch("source_port", got.source_port, want.source_port);
        if (got.dest_port !== want.dest_port)
            flag_mismatch("dest_port", got.dest_port, want.dest_port);
        if (got.fin_flag !== want.fin_flag)
            flag_mismatch("fin_flag", got.fin_flag, want.fin_flag);
        if (got.rst_flag !== want.rst_flag)
            flag_mismatch("rst_flag", got.rst_flag, want.rst_flag);
        if (got.header_bytes !== want.header_bytes)
            flag_mismatch("header_bytes", got.header_bytes, want.header_bytes);
        if (got.payload_bytes !== want.payload_bytes)
            flag_mismatch("payload_bytes", got.payload_bytes, want.payload_bytes);
        if (got.stamp !== want.stamp)
            flag_mismatch("stamp", got.stamp, want.stamp);
    endtask

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            check_result(m_data);
    end

    // Result side: random stalls per word, and one long hold when asked for.
    initial begin : result_sink
        int wait_cycles;
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
            if (hold_long) begin
                wait_cycles += HOLD_CYCLES;
                hold_long = 1'b0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input in_word_t w, input bit pin, input logic [2:0] pin_st,
                             input logic [63:0] first_time);
        int gap;
        out_word_t res;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (parse_byte(w, res)) begin
            // Plain failures carry only the status and the stamp.
            if (pin) begin
                res = '0;
                res.parse_status = pin_st;
                res.stamp = first_time;
            end
            expected_q.push_back(res);
        end
    endtask

    // Fills frame_bytes with random content and the header bytes that steer the parse.
    function automatic void build_frame(input logic [3:0] ver, ihl, input logic [7:0] proto,
                                        input logic [3:0] off, input logic [7:0] flags,
                                        input int rem);
        int total, base, l4;
        base = int'(link_hdr_len);
        total = base + rem;
        if (total == 0)
            total = 1;
        l4 = (ver == IP_VER6) ? 40 : 4 * int'(ihl);
        frame_bytes.delete();
        repeat (total) frame_bytes.push_back(8'($urandom));
        if (base < total)
            frame_bytes[base] = {ver, ihl};
        if (ver == IP_VER6 && base + 6 < total)
            frame_bytes[base + 6] = proto;
        if (ver != IP_VER6 && base + 9 < total)
            frame_bytes[base + 9] = proto;
        if (base + l4 + 12 < total)
            frame_bytes[base + l4 + 12] = {off, 4'($urandom)};
        if (base + l4 + 13 < total)
            frame_bytes[base + l4 + 13] = flags;
    endfunction

    task automatic send_frame(input bit pin, input logic [2:0] pin_st);
        in_word_t w;
        logic [63:0] first_time;
        first_time = '0;
        idle_on = ($urandom_range(0, 3) != 0);
        foreach (frame_bytes[i]) begin
            w.frame_byte = frame_bytes[i];
            w.frame_last = (i == frame_bytes.size() - 1);
            w.arrival_time = {$urandom, $urandom};
            if (i == 0)
                first_time = w.arrival_time;
            send_word(w, pin, pin_st, first_time);
        end
    endtask

    // Stops offering words and waits until every expected result has come out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready; psel stays high afterwards.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= LINK_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
    endtask

    // Writes the link header length while idle and reads it back.
    task automatic set_link(input logic [6:0] v);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, {25'd0, v}, rd);
        link_hdr_len = v;
        apb_access(1'b0, 32'd0, rd);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[6:0] !== v)
            flag_mismatch("link header readback", rd[6:0], v);
    endtask

    // Mostly well-formed IPv4/IPv6 frames with TCP or UDP, some cut short, some noise.
    task automatic random_frame();
        int kind, rem, need;
        logic [3:0] ver, ihl, off;
        logic [7:0] proto, flags;
        kind = $urandom_range(0, 99);
        ver = $urandom_range(0, 1) ? IP_VER6 : IP_VER4;
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        off = 4'($urandom);
        flags = 8'($urandom);
        need = (ver == IP_VER6) ? IPV6_NEED : 4 * int'(ihl) + 4;
        if (kind < 80) begin
            rem = need + $urandom_range(0, 40);
            if ($urandom_range(0, 9) == 0)
                rem += $urandom_range(0, 300);
        end else if (kind < 90) begin
            rem = $urandom_range(0, need);
        end else begin
            if ($urandom_range(0, 1))
                ver = 4'($urandom);
            ihl = 4'($urandom);
            if ($urandom_range(0, 1))
                proto = 8'($urandom);
            rem = $urandom_range(0, 80);
        end
        build_frame(ver, ihl, proto, off, flags, rem);
        send_frame(1'b0, STATUS_IPV4_OK);
    endtask

    // Stimulus: reset, directed frames, then random phases over several link header lengths.
    initial begin : frame_source
        int phase_bytes, phase_frames;
        logic [6:0] phase_link [6];
        phase_link = '{7'd14, 7'd0, 7'd64, 7'd127, 7'd1, 7'd0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].link != link_hdr_len)
                set_link(DIRECTED[k].link);
            build_frame(DIRECTED[k].ver, DIRECTED[k].ihl, DIRECTED[k].proto, DIRECTED[k].off,
                        DIRECTED[k].flags, int'(DIRECTED[k].rem));
            send_frame(DIRECTED[k].pin, DIRECTED[k].status);
        end

        for (int p = 0; p < 6; p++) begin
            set_link((p == 5) ? 7'($urandom_range(0, 127)) : phase_link[p]);
            // One phase holds results back long enough for the input to stall.
            if (p == 2)
                hold_long = 1'b1;
            phase_bytes = 0;
            phase_frames = 0;
            while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
                random_frame();
                phase_bytes += frame_bytes.size();
                phase_frames++;
            end
        end

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: ip_l4_header_parser_unit.f
src/ipl4hp_pkg.sv
src/ip_l4_header_parser_unit.sv
src/ipl4hp_checker.sv
test/testbench.sv
